@@ rtl/jsff_pkg.sv @@
// Shared types and constants for the first-fit job shop scheduler.
// No dependencies.
`default_nettype none
package jsff_pkg;
   localparam int unsigned WORD_BITS = 64;
   localparam int unsigned SLOT_W = 12;
   localparam int unsigned JOB_W = 5;
   localparam int unsigned MACH_W = 5;
   localparam int unsigned DUR_W = 8;
   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [WORD_BITS-1:0] word_type;
endpackage
`default_nettype wire

@@ rtl/job_shop_first_fit_scheduler_top.sv @@
// Top level of the first-fit job shop scheduler.
// Depends on jsff_pkg and jsff_ram.
//
// Usage: pulse start with req_job, req_machine, req_duration while busy is low.
// The block reads the job's last finish, then walks the machine's busy bitmap
// one 64-slot word per cycle from the slot after that finish, carrying the
// current run of free slots. Once the run reaches the duration it writes the
// reserved bits back, word by word, walking down from the finishing word.
// One result is shown for one cycle with rsp_valid; the receiver cannot stall.
// From the accepting edge the request passes the read state, then the scan state
// for each word scanned (up to the horizon in words), then a read and a write
// for each word rewritten (up to five for a 255-slot run), then the done state.
// A request with zero duration or a bad index goes straight to the done state,
// one whose job finished at the horizon via the read state. busy drops in the
// result cycle, so the next request can be taken at the edge that ends it.
// Each scan cycle handles one bitmap word: the memory read port sets the pace.
// After reset a clearing pass writes zero to every bitmap word, one word per
// cycle; busy stays high meanwhile. The job finish table sits in flip-flops
// cleared at reset.
`default_nettype none
module job_shop_first_fit_scheduler_top #(
   parameter int MACHINES = 32,
   parameter int JOBS = 32,
   parameter int HORIZON = 4096
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [jsff_pkg::JOB_W-1:0]  req_job,
   input  wire logic [jsff_pkg::MACH_W-1:0] req_machine,
   input  wire logic [jsff_pkg::DUR_W-1:0]  req_duration,
   output logic                             rsp_valid,
   output logic [jsff_pkg::SLOT_W-1:0]      rsp_start_slot,
   output logic [jsff_pkg::SLOT_W-1:0]      rsp_finish_slot,
   output logic [jsff_pkg::SLOT_W-1:0]      rsp_makespan,
   output logic                             rsp_overflow
);
   import jsff_pkg::*;
   localparam int WPM = (HORIZON + 63) / 64;
   localparam int WB = (WPM > 1) ? $clog2(WPM) : 1;
   localparam int MB = (MACHINES > 1) ? $clog2(MACHINES) : 1;
   localparam int DEPTH = (1 << MB) * (1 << WB);
   localparam int AW = MB + WB;
   localparam int SW = $clog2(HORIZON) + 1;
   localparam int JB = (JOBS > 1) ? $clog2(JOBS) : 1;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_READ, S_SCAN, S_WRITE, S_DONE
   } state_type;

   state_type state_ff;
   logic [AW-1:0] clr_ff;
   logic [JB-1:0] job_ff;
   logic [MB-1:0] mach_ff;
   logic [DUR_W-1:0] dur_ff;
   logic [SW-1:0] slot_ff;  // first slot of the word being scanned
   logic [SW-1:0] first_ff; // first slot allowed
   logic [8:0] run_ff;
   logic [SW-1:0] fin_ff, st_ff;
   logic [WB-1:0] wp_ff;    // word being read (lookahead) / written
   logic wvalid_ff;
   logic [SW-1:0] jf_ff [JOBS];
   logic [SW-1:0] max_ff;
   logic ovf_ff, valid_ff;
   logic [SLOT_W-1:0] o_st_ff, o_fin_ff;

   logic wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   word_type wr_data, rd_data;

   jsff_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_map (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data));

   // scan of one word: free run ending at every bit and first fit inside it
   word_type blocked;
   logic [8:0] run_at [64];
   logic [8:0] run_scan;
   logic hit;
   logic [5:0] hit_bit;

   // slots below the first allowed one or past the horizon count as taken
   always_comb begin
      logic [SW-1:0] s;
      for (int b = 0; b < 64; b++) begin
         s = slot_ff + SW'(b);
         blocked[b] = rd_data[b] || (s < first_ff) || (s >= SW'(HORIZON));
      end
   end

   // run length from the nearest taken bit below, or carried in from earlier words
   always_comb begin
      logic [6:0] above;
      for (int b = 0; b < 64; b++) begin
         above = '0;
         for (int k = 0; k <= b; k++)
            if (blocked[k]) above = 7'(k + 1);
         if (above != '0) run_at[b] = 9'(b + 1) - {2'b00, above};
         else run_at[b] = run_ff + 9'(b + 1);
      end
   end

   // lowest bit where the run covers the duration
   always_comb begin
      hit = 1'b0;
      hit_bit = '0;
      for (int b = 63; b >= 0; b--) begin
         if (run_at[b] >= {1'b0, dur_ff}) begin
            hit = 1'b1;
            hit_bit = 6'(b);
         end
      end
      run_scan = run_at[63];
   end

   // mask of reserved slots inside the word being written
   word_type wmask;
   always_comb begin
      logic [SW-1:0] s;
      wmask = '0;
      for (int b = 0; b < 64; b++) begin
         s = SW'({wp_ff, 6'd0}) + SW'(b);
         wmask[b] = (s >= st_ff) && (s <= fin_ff);
      end
   end

   logic [SW-1:0] hit_slot;
   assign hit_slot = slot_ff + SW'(hit_bit);
   logic [SW-1:0] next_slot;
   assign next_slot = slot_ff + SW'(64);

   // memory port steering
   always_comb begin
      wr_en = 1'b0;
      wr_addr = clr_ff;
      wr_data = '0;
      rd_addr = {mach_ff, slot_ff[6 +: WB]};
      case (state_ff)
         S_CLEAR: wr_en = 1'b1;
         S_SCAN: rd_addr = {mach_ff, wp_ff};
         S_WRITE: begin
            rd_addr = {mach_ff, wp_ff};
            wr_addr = {mach_ff, wp_ff};
            wr_en = wvalid_ff;
            wr_data = rd_data | wmask;
         end
         default: ;
      endcase
   end

   // control sequence
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         max_ff <= '0;
         valid_ff <= 1'b0;
         for (int j = 0; j < JOBS; j++) jf_ff[j] <= '0;
      end else begin
         valid_ff <= 1'b0;
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == AW'(DEPTH - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: if (start) begin
               job_ff <= JB'(req_job);
               mach_ff <= MB'(req_machine);
               dur_ff <= req_duration;
               run_ff <= '0;
               if (32'(req_job) >= JOBS || 32'(req_machine) >= MACHINES
                     || req_duration == '0) begin
                  ovf_ff <= 1'b1;
                  state_ff <= S_DONE;
               end else begin
                  ovf_ff <= 1'b0;
                  first_ff <= jf_ff[JB'(req_job)] + SW'(1);
                  slot_ff <= (jf_ff[JB'(req_job)] + SW'(1)) & ~SW'(63);
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               // address issued from slot_ff; data next cycle
               if (slot_ff >= SW'(HORIZON)) begin
                  ovf_ff <= 1'b1;
                  state_ff <= S_DONE;
               end else begin
                  wp_ff <= WB'(next_slot >> 6);
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (hit) begin
                  fin_ff <= hit_slot;
                  st_ff <= hit_slot - SW'(dur_ff) + SW'(1);
                  wp_ff <= hit_slot[6 +: WB];
                  wvalid_ff <= 1'b0;
                  state_ff <= S_WRITE;
               end else if (next_slot >= SW'(HORIZON)) begin
                  ovf_ff <= 1'b1;
                  state_ff <= S_DONE;
               end else begin
                  run_ff <= run_scan;
                  slot_ff <= next_slot;
                  wp_ff <= wp_ff + WB'(1);
               end
            end
            S_WRITE: begin
               // each word is read, then written back with the reserved bits, before the next one down
               if (!wvalid_ff) wvalid_ff <= 1'b1;
               else if (SW'({wp_ff, 6'd0}) <= st_ff) state_ff <= S_DONE;
               else begin
                  wp_ff <= wp_ff - WB'(1);
                  wvalid_ff <= 1'b0;
               end
            end
            S_DONE: begin
               valid_ff <= 1'b1;
               if (!ovf_ff) begin
                  jf_ff[job_ff] <= fin_ff;
                  if (fin_ff > max_ff) max_ff <= fin_ff;
                  o_st_ff <= SLOT_W'(st_ff);
                  o_fin_ff <= SLOT_W'(fin_ff);
               end else begin
                  o_st_ff <= '0;
                  o_fin_ff <= '0;
               end
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = valid_ff;
   assign rsp_start_slot = o_st_ff;
   assign rsp_finish_slot = o_fin_ff;
   assign rsp_makespan = SLOT_W'(max_ff);
   assign rsp_overflow = ovf_ff;
endmodule
`default_nettype wire

@@ rtl/jsff_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none
module jsff_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

@@ rtl/jsff_checker.sv @@
// Port-level checks for the scheduler top level, with its bind.
// Depends on job_shop_first_fit_scheduler_top.
`default_nettype none
module jsff_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_valid,
   input wire logic [11:0] rsp_start_slot,
   input wire logic [11:0] rsp_finish_slot,
   input wire logic [11:0] rsp_makespan,
   input wire logic rsp_overflow
);
   // a request makes the block busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("not busy after request");
   // a result is a single cycle strobe
   a_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result longer than a cycle");
   // overflow reserves nothing
   a_ovf: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_overflow) |-> (rsp_start_slot == 12'd0 && rsp_finish_slot == 12'd0))
      else $error("overflow with slots");
   // reservation ordering
   a_ord: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_overflow) |->
         (rsp_start_slot <= rsp_finish_slot && rsp_finish_slot <= rsp_makespan))
      else $error("bad slot order");
endmodule
bind job_shop_first_fit_scheduler_top jsff_checker u_chk (.*);
`default_nettype wire
